### design/rau_pkg.sv
// ---------------------------------------------------------------------------
// rau_pkg: rational arithmetic unit shared types and constants
// Opcode and status codes, field widths and stream word widths.
// ---------------------------------------------------------------------------
package rau_pkg;

	localparam int NUM_W      = 32;
	localparam int DEN_W      = 31;
	localparam int PROD_W     = 64;
	localparam int IN_DATA_W  = 128;
	localparam int OUT_DATA_W = 72;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK  = 2'd0,
		STAT_DZ  = 2'd1,
		STAT_OVF = 2'd2
	} status_t;

endpackage

### design/rational_arithmetic_unit.sv
// ---------------------------------------------------------------------------
// rational_arithmetic_unit: reduced fraction add, subtract, multiply, divide, compare
// Steps per word: the products on the shared multiplier, setup and sign,
// binary gcd steps, then two 64-step restoring divisions by the gcd on one
// divider, then finish; a zero denominator goes from sign straight to finish.
// One word at a time; the next word is taken the cycle after the result is
// registered, later while a previous result still waits on m_axis_tready.
// arst_n clears the sequencer and the output valid; data registers keep junk.
// ---------------------------------------------------------------------------
module rational_arithmetic_unit
	import rau_pkg::*;
#(
	parameter int WORD_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// a_num[31:0], a_den[62:32], b_num[94:63], b_den[125:95], zero pad
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	// op[1:0]
	input  logic [1:0]            s_axis_tuser,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// res_num[31:0], res_den[62:32], status[64:63], is_less[65],
	// is_equal[66], is_greater[67], zero pad
	output logic [OUT_DATA_W-1:0] m_axis_tdata
);

	localparam logic [PROD_W-1:0] LIM = PROD_W'(1) << (WORD_BITS - 1);

	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL,
		S_SETUP,
		S_SIGN,
		S_GCD,
		S_DIVN,
		S_DIVD,
		S_FIN
	} state_t;

	state_t                   state_q;
	op_t                      op_q;
	logic signed [NUM_W-1:0]  an_q, bn_q;
	logic        [DEN_W-1:0]  ad_q, bd_q;
	logic                     eq_q, lt_q, gt_q, dz_q, neg_q;
	logic        [1:0]        mcnt_q;
	logic signed [PROD_W-1:0] p1_q, p2_q, p3_q, p4_q, num_q, den_q;
	logic        [PROD_W-1:0] nm_q, dm_q, u_q, v_q, g_q, q_q;
	logic        [PROD_W:0]   r_q;
	logic        [5:0]        k_q, cnt_q;
	logic                     m_valid_q;
	logic [OUT_DATA_W-1:0]    m_data_q;

	logic signed [NUM_W:0]    mx, my;
	logic signed [2*NUM_W+1:0] mprod;
	logic signed [PROD_W-1:0] num_c, den_c;
	logic        [PROD_W:0]   rs, rsub;
	logic        [PROD_W-1:0] q_nxt;
	logic        [PROD_W:0]   r_nxt;
	logic        [PROD_W-1:0] fn, fd;
	logic                     fneg, fovf;
	status_t                  fstat;
	logic        [NUM_W-1:0]  fnum;
	logic        [DEN_W-1:0]  fden;

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

	always_comb begin
		unique case (mcnt_q)
			2'd0: begin mx = {an_q[NUM_W-1], an_q}; my = {2'b00, bd_q}; end
			2'd1: begin mx = {2'b00, ad_q}; my = {bn_q[NUM_W-1], bn_q}; end
			2'd2: begin mx = {an_q[NUM_W-1], an_q}; my = {bn_q[NUM_W-1], bn_q}; end
			default: begin mx = {2'b00, ad_q}; my = {2'b00, bd_q}; end
		endcase
		mprod = mx * my;
	end

	always_comb begin
		unique case (op_q)
			OP_ADD: begin num_c = p1_q + p2_q; den_c = p4_q; end
			OP_SUB: begin num_c = p1_q - p2_q; den_c = p4_q; end
			OP_MUL: begin num_c = p3_q; den_c = p4_q; end
			default: begin num_c = p1_q; den_c = p2_q; end
		endcase
	end

	always_comb begin
		rs   = {r_q[PROD_W-1:0], q_q[PROD_W-1]};
		rsub = rs - {1'b0, g_q};
		if (rs >= {1'b0, g_q}) begin
			r_nxt = rsub;
			q_nxt = {q_q[PROD_W-2:0], 1'b1};
		end else begin
			r_nxt = rs;
			q_nxt = {q_q[PROD_W-2:0], 1'b0};
		end
	end

	always_comb begin
		fn   = nm_q;
		fd   = q_q;
		fneg = neg_q;
		if (fn == '0) begin
			fneg = 1'b0;
			fd   = PROD_W'(1);
		end
		fovf = (fd > LIM - 1) || (fneg ? (fn > LIM) : (fn > LIM - 1));
		if (dz_q) begin
			fstat = STAT_DZ;
			fnum  = '0;
			fden  = DEN_W'(1);
		end else if (fovf) begin
			fstat = STAT_OVF;
			fnum  = '0;
			fden  = DEN_W'(1);
		end else begin
			fstat = STAT_OK;
			fnum  = fneg ? (NUM_W'(0) - fn[NUM_W-1:0]) : fn[NUM_W-1:0];
			fden  = fd[DEN_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			m_valid_q <= 1'b0;
			mcnt_q    <= '0;
		end else begin
			if (m_valid_q && m_axis_tready && state_q != S_FIN)
				m_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid) begin
						op_q    <= op_t'(s_axis_tuser);
						an_q    <= s_axis_tdata[31:0];
						ad_q    <= s_axis_tdata[62:32];
						bn_q    <= s_axis_tdata[94:63];
						bd_q    <= s_axis_tdata[125:95];
						mcnt_q  <= '0;
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					unique case (mcnt_q)
						2'd0: p1_q <= mprod[PROD_W-1:0];
						2'd1: p2_q <= mprod[PROD_W-1:0];
						2'd2: p3_q <= mprod[PROD_W-1:0];
						default: p4_q <= mprod[PROD_W-1:0];
					endcase
					mcnt_q <= mcnt_q + 2'd1;
					if (mcnt_q == 2'd3)
						state_q <= S_SETUP;
				end
				S_SETUP: begin
					num_q   <= num_c;
					den_q   <= den_c;
					lt_q    <= p1_q < p2_q;
					gt_q    <= p1_q > p2_q;
					eq_q    <= (an_q == bn_q) && (ad_q == bd_q);
					state_q <= S_SIGN;
				end
				S_SIGN: begin
					dz_q  <= (den_q == '0);
					neg_q <= num_q[PROD_W-1] != den_q[PROD_W-1];
					nm_q  <= num_q[PROD_W-1] ? PROD_W'(-num_q) : PROD_W'(num_q);
					dm_q  <= den_q[PROD_W-1] ? PROD_W'(-den_q) : PROD_W'(den_q);
					u_q   <= num_q[PROD_W-1] ? PROD_W'(-num_q) : PROD_W'(num_q);
					v_q   <= den_q[PROD_W-1] ? PROD_W'(-den_q) : PROD_W'(den_q);
					k_q   <= '0;
					state_q <= (den_q == '0) ? S_FIN : S_GCD;
				end
				S_GCD: begin
					priority if (u_q == '0) begin
						g_q     <= v_q << k_q;
						q_q     <= nm_q;
						r_q     <= '0;
						cnt_q   <= '0;
						state_q <= S_DIVN;
					end else if (!u_q[0] && !v_q[0]) begin
						u_q <= u_q >> 1;
						v_q <= v_q >> 1;
						k_q <= k_q + 6'd1;
					end else if (!u_q[0]) begin
						u_q <= u_q >> 1;
					end else if (!v_q[0]) begin
						v_q <= v_q >> 1;
					end else if (u_q >= v_q) begin
						u_q <= (u_q - v_q) >> 1;
					end else begin
						v_q <= (v_q - u_q) >> 1;
					end
				end
				S_DIVN: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd63) begin
						nm_q    <= q_nxt;
						q_q     <= dm_q;
						r_q     <= '0;
						state_q <= S_DIVD;
					end else begin
						q_q <= q_nxt;
						r_q <= r_nxt;
					end
				end
				S_DIVD: begin
					cnt_q <= cnt_q + 6'd1;
					q_q   <= q_nxt;
					r_q   <= r_nxt;
					if (cnt_q == 6'd63)
						state_q <= S_FIN;
				end
				S_FIN: begin
					if (!m_valid_q || m_axis_tready) begin
						m_valid_q <= 1'b1;
						m_data_q  <= {4'b0, gt_q, eq_q, lt_q, fstat, fden, fnum};
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_out_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(state_q == S_FIN))
		else $error("output word appeared outside finish");
	a_gcd_v_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_GCD |-> v_q != '0)
		else $error("gcd operand went to zero");
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIVN || state_q == S_DIVD) |-> g_q != '0)
		else $error("division by zero gcd");
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> state_q == S_MUL && mcnt_q == 2'd0)
		else $error("accepted word did not start multiply");
`endif

endmodule

### sim/tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb: rational arithmetic unit testbench
// Drives fraction pairs with each opcode over the input stream, predicts the
// reduced result, status and compare flags, and checks every output word in
// order under random source and sink stalls.
// ---------------------------------------------------------------------------
module tb
	import rau_pkg::*;
();

	typedef struct packed {
		logic               gt;
		logic               eq;
		logic               lt;
		status_t            status;
		logic [30:0]        den;
		logic signed [31:0] num;
	} answer_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata;
	logic [1:0]            s_axis_tuser;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;

	answer_t answers_due[$];
	int      errors;
	int      send_idle_pct;
	int      recv_idle_pct;
	int      quiet_cycles;

	rational_arithmetic_unit dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic [63:0] gcd_u64(logic [63:0] x, logic [63:0] y);
		logic [63:0] t;
		while (y != 0) begin
			t = x % y;
			x = y;
			y = t;
		end
		return x;
	endfunction

	function automatic answer_t compute_fraction(op_t op, logic signed [31:0] an,
			logic [30:0] ad, logic signed [31:0] bn, logic [30:0] bd);
		answer_t r;
		logic signed [63:0] an64, ad64, bn64, bd64, num, den, lhs, rhs;
		logic [63:0] nm, dm, g;
		logic neg;
		an64 = an;
		bn64 = bn;
		ad64 = {33'd0, ad};
		bd64 = {33'd0, bd};
		lhs = an64 * bd64;
		rhs = ad64 * bn64;
		case (op)
			OP_ADD: begin num = lhs + rhs; den = ad64 * bd64; end
			OP_SUB: begin num = lhs - rhs; den = ad64 * bd64; end
			OP_MUL: begin num = an64 * bn64; den = ad64 * bd64; end
			default: begin num = lhs; den = rhs; end
		endcase
		r.num = '0;
		r.den = 31'd1;
		r.status = STAT_OK;
		if (den == 0) begin
			r.status = STAT_DZ;
		end else begin
			neg = (num < 0) != (den < 0);
			nm = (num < 0) ? -num : num;
			dm = (den < 0) ? -den : den;
			g = gcd_u64(nm, dm);
			nm = nm / g;
			dm = dm / g;
			if (nm == 0) begin
				neg = 1'b0;
				dm = 64'd1;
			end
			if (dm > 64'h7fff_ffff || (neg ? nm > 64'h8000_0000 : nm > 64'h7fff_ffff)) begin
				r.status = STAT_OVF;
			end else begin
				r.num = neg ? -nm[31:0] : nm[31:0];
				r.den = dm[30:0];
			end
		end
		r.lt = lhs < rhs;
		r.eq = (an == bn) && (ad == bd);
		r.gt = lhs > rhs;
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %0h want %0h", what, got, want);
		errors++;
	endtask

	task automatic send_word(op_t op, logic signed [31:0] an, logic [30:0] ad,
			logic signed [31:0] bn, logic [30:0] bd);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tdata <= {2'b00, bd, bn, ad, an};
		answers_due.push_back(compute_fraction(op, an, ad, bn, bd));
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		@(negedge clk);
	endtask

	always @(negedge clk) m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);

	always @(posedge clk) begin
		answer_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata[67:0];
			if (answers_due.size() == 0) begin
				report_mismatch("unexpected word", m_axis_tdata[63:0], 64'd0);
			end else begin
				want = answers_due.pop_front();
				if (got.num != want.num)
					report_mismatch("res_num", 64'(got.num), 64'(want.num));
				if (got.den != want.den)
					report_mismatch("res_den", 64'(got.den), 64'(want.den));
				if (got.status != want.status)
					report_mismatch("status", 64'(got.status), 64'(want.status));
				if (got.lt != want.lt)
					report_mismatch("is_less", 64'(got.lt), 64'(want.lt));
				if (got.eq != want.eq)
					report_mismatch("is_equal", 64'(got.eq), 64'(want.eq));
				if (got.gt != want.gt)
					report_mismatch("is_greater", 64'(got.gt), 64'(want.gt));
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > 20000) begin
			$display("tb failed");
			$finish;
		end
	end

	function automatic logic signed [31:0] rand_num();
		case ($urandom_range(3))
			0: return $signed($urandom_range(20)) - 10;
			1: return $signed($urandom_range(2000)) - 1000;
			2: return $signed($urandom_range(200000)) - 100000;
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [30:0] rand_den();
		case ($urandom_range(3))
			0: return 31'($urandom_range(12, 1));
			1: return 31'($urandom_range(1000, 1));
			2: return 31'($urandom_range(100000, 1));
			default: return 31'($urandom_range(32'h7fff_ffff, 1));
		endcase
	endfunction

	task automatic test_directed();
		logic signed [31:0] nmin, nmax;
		nmin = 32'sh8000_0000;
		nmax = 32'sh7fff_ffff;
		for (int o = 0; o < 4; o++) begin
			send_word(op_t'(o), 1, 2, 1, 3);
			send_word(op_t'(o), nmax, 31'h7fff_ffff, nmin, 1);
			send_word(op_t'(o), nmin, 1, nmin, 1);
			send_word(op_t'(o), 0, 1, 0, 1);
			send_word(op_t'(o), 2, 4, 1, 2);
		end
		send_word(OP_DIV, 5, 7, 0, 3);
		send_word(OP_ADD, 3, 0, 1, 1);
		send_word(OP_MUL, 1, 1, 1, 0);
		send_word(OP_DIV, -7, 3, 7, 3);
		send_word(OP_SUB, nmax, 1, -1, 1);
	endtask

	task automatic test_random(int count);
		for (int i = 0; i < count; i++)
			send_word(op_t'($urandom_range(3)), rand_num(), rand_den(), rand_num(), rand_den());
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (answers_due.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	initial begin
		send_idle_pct = 33;
		recv_idle_pct = 75;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_random(330);
		send_idle_pct = 75;
		recv_idle_pct = 33;
		test_random(330);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random(340);
		drain();
		if (errors == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end
endmodule
